// ===== rtl/acf_pkg.sv =====
// Shared types and constants for the accounting compact-number codec.
`timescale 1ns / 1ps
package acf_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned EXP_W  = 6;   // holds the largest unsaturated comp2_t exponent + 1

    typedef enum logic [1:0] {
        CMD_ENC_COMP  = 2'd0,
        CMD_DEC_COMP  = 2'd1,
        CMD_ENC_COMP2 = 2'd2,
        CMD_DEC_COMP2 = 2'd3
    } t_cmd;

    localparam logic [20:0] CT_MAX_MANT = 21'h01FFF;
    localparam logic [20:0] C2_MAX_MANT = 21'h0FFFFF;
    localparam logic [EXP_W-1:0] C2_MAX_EXP = 6'd31;
    localparam logic [DATA_W-1:0] C2_SATURATE = 64'h0000_0000_00FF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic round;
        logic emit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic above_max;
        logic encode;
    } t_dp_stat;

endpackage

// ===== rtl/acf_dp.sv =====
// Datapath: operand register, normalizing shifter, rounding and packing/unpacking.
`timescale 1ns / 1ps
module acf_dp (
    input  logic                          i_clk,
    input  acf_pkg::t_dp_cmd              i_cmd,
    input  acf_pkg::t_cmd                 i_command,
    input  logic [acf_pkg::DATA_W-1:0]    i_operand,
    output acf_pkg::t_dp_stat             o_stat,
    output logic [acf_pkg::DATA_W-1:0]    o_result,
    output logic                          o_overflow
);
    import acf_pkg::*;

    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_val;
    logic [EXP_W-1:0]  r_exp;
    logic              r_up;
    logic [DATA_W-1:0] r_result;
    logic              r_overflow;

    logic [DATA_W-1:0] n_val;
    logic [EXP_W-1:0]  n_exp;
    logic              n_up;
    logic [DATA_W-1:0] n_result;
    logic              n_overflow;

    logic              is_c2;
    logic [20:0]       v_inc;
    logic [2:0]        dc_exp;
    logic [4:0]        d2_exp;
    logic [4:0]        d2_sh;
    logic [DATA_W-1:0] dc_val;
    logic [DATA_W-1:0] d2_val;

    always_comb begin
        is_c2 = r_cmd[1];
        o_stat.above_max = is_c2 ? (|r_val[DATA_W-1:20]) : (|r_val[DATA_W-1:13]);
        o_stat.encode    = (r_cmd == CMD_ENC_COMP) || (r_cmd == CMD_ENC_COMP2);
    end

    always_comb begin
        // value is at most 20 bits once normalized
        v_inc  = r_val[20:0] + 21'd1;
        dc_exp = r_val[15:13];
        d2_exp = r_val[23:19];
        d2_sh  = d2_exp - 5'd1;
        dc_val = {51'd0, r_val[12:0]} << ({3'd0, dc_exp} * 6'd3);
        if (d2_exp == 5'd0) begin
            d2_val = {45'd0, r_val[18:0]};
        end else begin
            d2_val = {44'd0, 1'b1, r_val[18:0]} << d2_sh;
        end
    end

    always_comb begin
        n_val      = r_val;
        n_exp      = r_exp;
        n_up       = r_up;
        n_result   = r_result;
        n_overflow = r_overflow;
        if (i_cmd.load) begin
            n_val = i_operand;
            n_up  = 1'b0;
            n_exp = ((i_command == CMD_ENC_COMP2) && (|i_operand[DATA_W-1:19]))
                    ? EXP_W'(1) : EXP_W'(0);
        end else if (i_cmd.shift) begin
            if (is_c2) begin
                n_up  = r_val[0];
                n_val = r_val >> 1;
            end else begin
                n_up  = r_val[2];
                n_val = r_val >> 3;
            end
            n_exp = r_exp + EXP_W'(1);
        end else if (i_cmd.round) begin
            if (r_up) begin
                if (is_c2) begin
                    if (v_inc > C2_MAX_MANT) begin
                        n_val = {43'd0, v_inc >> 1};
                        n_exp = r_exp + EXP_W'(1);
                    end else begin
                        n_val = {43'd0, v_inc};
                    end
                end else begin
                    if (v_inc > CT_MAX_MANT) begin
                        n_val = {43'd0, v_inc >> 3};
                        n_exp = r_exp + EXP_W'(1);
                    end else begin
                        n_val = {43'd0, v_inc};
                    end
                end
            end
        end else if (i_cmd.emit) begin
            n_overflow = 1'b0;
            case (r_cmd)
                CMD_ENC_COMP: begin
                    n_result   = {48'd0, r_exp[2:0], r_val[12:0]};
                    n_overflow = (r_exp > EXP_W'(7));
                end
                CMD_DEC_COMP: begin
                    n_result = dc_val;
                end
                CMD_ENC_COMP2: begin
                    if (r_exp > C2_MAX_EXP) begin
                        n_result   = C2_SATURATE;
                        n_overflow = 1'b1;
                    end else begin
                        n_result = {40'd0, r_exp[4:0], r_val[18:0]};
                    end
                end
                default: begin
                    n_result = d2_val;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
        end
        r_val      <= n_val;
        r_exp      <= n_exp;
        r_up       <= n_up;
        r_result   <= n_result;
        r_overflow <= n_overflow;
    end

    assign o_result   = r_result;
    assign o_overflow = r_overflow;

endmodule

// ===== rtl/acf_ctrl.sv =====
// Controller: sequences load, normalize, round and emit for one request.
`timescale 1ns / 1ps
module acf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  acf_pkg::t_dp_stat    i_stat,
    output acf_pkg::t_dp_cmd     o_cmd,
    output logic                 o_busy,
    output logic                 o_done
);
    import acf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_NORM  = 4'b0010,
        S_ROUND = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_NORM;
                end
            end
            S_NORM: begin
                if (!i_stat.encode) begin
                    n_state = S_EMIT;
                end else if (i_stat.above_max) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.emit;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== rtl/acct_comp_float_codec.sv =====
// Top level of the accounting compact-number codec (comp_t / comp2_t).
`timescale 1ns / 1ps
// One request at a time: a request is taken when start is high and busy low, and
// its result shows on o_result/o_overflow with o_done, a one-cycle strobe that
// cannot be held off. Decodes go from normalize straight to emit; encodes first
// shift to normalize with the single shifter (3 bits a step for comp_t, at most
// 17 steps; 1 bit a step for comp2_t, at most 44 steps), then round and emit.
// The result appears in the same cycle as busy falls, and a new request may be
// given in that same cycle.
module acct_comp_float_codec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  acf_pkg::t_cmd              i_command,
    input  logic [acf_pkg::DATA_W-1:0] i_operand,
    output logic                       o_done,
    output logic [acf_pkg::DATA_W-1:0] o_result,
    output logic                       o_overflow
);
    import acf_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    acf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    acf_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .i_command  (i_command),
        .i_operand  (i_operand),
        .o_stat     (dp_stat),
        .o_result   (o_result),
        .o_overflow (o_overflow)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |=> (o_done && !busy))
        else $error("emit not followed by result strobe");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.load, dp_cmd.shift, dp_cmd.round, dp_cmd.emit}))
        else $error("conflicting datapath commands");

endmodule

// ===== tb/sv/acct_comp_float_codec_test.sv =====
// Self-checking testbench for the comp_t / comp2_t compact-number codec.
`timescale 1ns / 1ps
module acct_comp_float_codec_test;
    import acf_pkg::*;

    localparam int unsigned N_DIRECTED = 25;
    localparam int unsigned N_PHASE    = 342;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned DRAIN_CYC  = 60;
    localparam logic [63:0] CT_MANT_MASK  = 64'h1FFF;
    localparam logic [63:0] C2_MANT_MASK  = 64'h7FFFF;
    localparam logic [63:0] C2_FULL_MANT  = 64'hFFFFF;

    typedef struct {
        t_cmd        cmd;
        logic [63:0] op;
        bit          typed;
        logic [63:0] res;
        logic        ovf;
    } t_conv_row;

    typedef struct {
        logic [63:0] res;
        logic        ovf;
        t_cmd        cmd;
        logic [63:0] op;
    } t_conv_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_command;
    logic [63:0] i_operand;
    logic        o_done;
    logic [63:0] o_result;
    logic        o_overflow;

    // typed expectation for the request currently offered (directed rows only)
    bit          req_typed;
    logic [63:0] req_res;
    logic        req_ovf;

    t_conv_exp   pending_q[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_idle;
    int unsigned cmd_count[4];
    int unsigned sender_idle_pct;

    t_conv_row dir_tab [N_DIRECTED] = '{
        '{CMD_ENC_COMP,  64'd0,                   1'b1, 64'd0,       1'b0},
        '{CMD_ENC_COMP,  64'd8191,                1'b1, 64'h1FFF,    1'b0},
        '{CMD_ENC_COMP,  64'd8192,                1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP,  64'd65535,               1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP,  64'h1F_FFFF_FFFF,        1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP,  64'h20_0000_0000,        1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0,       1'b0},
        '{CMD_DEC_COMP,  64'd0,                   1'b1, 64'd0,       1'b0},
        '{CMD_DEC_COMP,  64'h1FFF,                1'b1, 64'd8191,    1'b0},
        '{CMD_DEC_COMP,  64'hFFFF,                1'b0, 64'd0,       1'b0},
        '{CMD_DEC_COMP,  64'hFFFF_FFFF_FFFF_0000, 1'b1, 64'd0,       1'b0},
        '{CMD_DEC_COMP,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'd0,                   1'b1, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'h7FFFF,               1'b1, 64'h7FFFF,   1'b0},
        '{CMD_ENC_COMP2, 64'h80000,               1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'hFFFFF,               1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'h100000,              1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'h1FFFFF,              1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'h3_FFFF_FFFF_FFFF,    1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'h2_0000_0000_0000,    1'b0, 64'd0,       1'b0},
        '{CMD_ENC_COMP2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFFFF,  1'b1},
        '{CMD_DEC_COMP2, 64'd0,                   1'b1, 64'd0,       1'b0},
        '{CMD_DEC_COMP2, 64'h7FFFF,               1'b1, 64'h7FFFF,   1'b0},
        '{CMD_DEC_COMP2, 64'hFFFFFF,              1'b0, 64'd0,       1'b0},
        '{CMD_DEC_COMP2, 64'hFFFF_FFFF_FF08_0000, 1'b0, 64'd0,       1'b0}
    };

    acct_comp_float_codec i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_operand  (i_operand),
        .o_done     (o_done),
        .o_result   (o_result),
        .o_overflow (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---- conversion predictor ----
    function automatic void enc_comp_t(input logic [63:0] val, output logic [63:0] code,
                                       output logic ovf);
        logic [63:0] v;
        int unsigned e;
        logic        up;
        v  = val;
        e  = 0;
        up = 1'b0;
        while (v > CT_MANT_MASK) begin
            up = v[2];
            v  = v >> 3;
            e++;
        end
        if (up) begin
            v = v + 64'd1;
            if (v > CT_MANT_MASK) begin
                v = v >> 3;
                e++;
            end
        end
        code = ((64'(e) << 13) + v) & 64'hFFFF;
        ovf  = (e > 7);
    endfunction

    function automatic void enc_comp2_t(input logic [63:0] val, output logic [63:0] code,
                                        output logic ovf);
        logic [63:0] v;
        int unsigned e;
        logic        up;
        v  = val;
        e  = (v > C2_MANT_MASK) ? 1 : 0;
        up = 1'b0;
        while (v > C2_FULL_MANT) begin
            up = v[0];
            v  = v >> 1;
            e++;
        end
        if (up) begin
            v = v + 64'd1;
            if (v > C2_FULL_MANT) begin
                v = v >> 1;
                e++;
            end
        end
        if (e > 31) begin
            code = C2_SATURATE;
            ovf  = 1'b1;
        end else begin
            code = (v & C2_MANT_MASK) | (64'(e) << 19);
            ovf  = 1'b0;
        end
    endfunction

    function automatic logic [63:0] dec_comp_t(input logic [63:0] code);
        logic [63:0] mant;
        int unsigned e;
        mant = code & CT_MANT_MASK;
        e    = int'(code[15:13]);
        return mant << (3 * e);
    endfunction

    function automatic logic [63:0] dec_comp2_t(input logic [63:0] code);
        logic [63:0] mant;
        int unsigned e;
        mant = code & C2_MANT_MASK;
        e    = int'(code[23:19]);
        if (e == 0)
            return mant;
        mant[19] = 1'b1;
        return mant << (e - 1);
    endfunction

    function automatic t_conv_exp predict_conv(input t_cmd c, input logic [63:0] op);
        t_conv_exp x;
        x.cmd = c;
        x.op  = op;
        x.ovf = 1'b0;
        case (c)
            CMD_ENC_COMP:  enc_comp_t(op, x.res, x.ovf);
            CMD_DEC_COMP:  x.res = dec_comp_t(op);
            CMD_ENC_COMP2: enc_comp2_t(op, x.res, x.ovf);
            default:       x.res = dec_comp2_t(op);
        endcase
        return x;
    endfunction

    task automatic report_mismatch(input string what, input t_conv_exp x,
                                   input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: cmd=%s op=%h got=%h want=%h", what, x.cmd.name(), x.op,
                 got, want);
        n_errors++;
    endtask

    // ---- monitor: records accepted requests, checks results, watchdog ----
    always @(posedge i_clk) begin
        t_conv_exp x;
        bit        active;
        active = 1'b0;
        if (i_rst_n && o_done === 1'b1) begin
            active = 1'b1;
            if (pending_q.size() == 0) begin
                x.cmd = CMD_ENC_COMP;
                x.op  = '0;
                report_mismatch("unexpected result", x, o_result, 64'd0);
            end else begin
                x = pending_q.pop_front();
                n_checked++;
                if (o_result !== x.res)
                    report_mismatch("result", x, o_result, x.res);
                if (o_overflow !== x.ovf)
                    report_mismatch("overflow", x, 64'(o_overflow), 64'(x.ovf));
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            active = 1'b1;
            x = predict_conv(i_command, i_operand);
            if (req_typed) begin
                x.res = req_res;
                x.ovf = req_ovf;
            end
            pending_q.push_back(x);
            cmd_count[int'(i_command)]++;
        end
        n_idle = active ? 0 : n_idle + 1;
        if (n_idle >= IDLE_LIMIT) begin
            $display("timeout: no activity for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---- stimulus ----
    task automatic issue(input t_cmd c, input logic [63:0] op, input bit typed,
                         input logic [63:0] res, input logic ovf);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= c;
        i_operand <= op;
        req_typed = typed;
        req_res   = res;
        req_ovf   = ovf;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] full;
        logic [63:0] mask;
        int unsigned w;
        int unsigned pick;
        full = {$urandom, $urandom};
        w    = $urandom_range(64, 0);
        mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        pick = $urandom_range(9);
        if (pick < 6)
            return full & mask;
        if (pick < 8)   // near a power of two: exercises rounding carries
            return mask + 64'($urandom_range(2)) - 64'd1;
        return full;
    endfunction

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_ENC_COMP;
        i_operand       = '0;
        req_typed       = 1'b0;
        req_res         = '0;
        req_ovf         = 1'b0;
        n_errors        = 0;
        n_checked       = 0;
        n_idle          = 0;
        sender_idle_pct = 7;
        foreach (cmd_count[k]) cmd_count[k] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k])
            issue(dir_tab[k].cmd, dir_tab[k].op, dir_tab[k].typed, dir_tab[k].res,
                  dir_tab[k].ovf);

        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct = (ph == 0) ? 7 : ((ph == 1) ? 76 : 0);
            repeat (N_PHASE)
                issue(t_cmd'($urandom_range(3)), rand_operand(), 1'b0, '0, 1'b0);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Requests: enc comp_t %0d, dec comp_t %0d, enc comp2_t %0d, dec comp2_t %0d",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
        $display("Results checked: %0d, mismatches: %0d, sender idle 7/76/0 percent",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== acct_comp_float_codec.f =====
rtl/acf_pkg.sv
rtl/acf_dp.sv
rtl/acf_ctrl.sv
rtl/acct_comp_float_codec.sv
tb/sv/acct_comp_float_codec_test.sv
